[sv/e2q_pkg.sv]
// Package with the types, constants and tables of the Euler angle to quaternion converter.
package e2q_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int QUAT_BITS = 16;
    localparam int CORDIC_STEPS = 30;
    localparam int ZW = 34;
    localparam int XW = 34;

    localparam logic signed [ZW-1:0] FIX_PI = 34'sd3373259426;
    localparam logic signed [ZW-1:0] FIX_HALF_PI = 34'sd1686629713;
    localparam logic signed [XW-1:0] FIX_INV_GAIN = 34'sd652032874;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] roll_angle;
        logic signed [ANGLE_BITS-1:0] pitch_angle;
        logic signed [ANGLE_BITS-1:0] yaw_angle;
    } t_in_word;

    typedef struct packed {
        logic signed [QUAT_BITS-1:0] quat_x;
        logic signed [QUAT_BITS-1:0] quat_y;
        logic signed [QUAT_BITS-1:0] quat_z;
        logic signed [QUAT_BITS-1:0] quat_w;
    } t_out_word;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 flip;
    } t_cordic;

    typedef t_cordic [2:0] t_cell_bus;

    function automatic logic signed [ZW-1:0] atan_value(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            5'd0: v = 34'sh03243F6A8;
            5'd1: v = 34'sh01DAC6705;
            5'd2: v = 34'sh00FADBAFC;
            5'd3: v = 34'sh007F56EA6;
            5'd4: v = 34'sh003FEAB76;
            5'd5: v = 34'sh001FFD55B;
            5'd6: v = 34'sh000FFFAAA;
            5'd7: v = 34'sh0007FFF55;
            5'd8: v = 34'sh0003FFFEA;
            5'd9: v = 34'sh0001FFFFD;
            5'd10: v = 34'sh000FFFFF;
            5'd11: v = 34'sh0007FFFF;
            5'd12: v = 34'sh0003FFFF;
            5'd13: v = 34'sh0001FFFF;
            5'd14: v = 34'sh0000FFFF;
            5'd15: v = 34'sh00007FFF;
            5'd16: v = 34'sh00003FFF;
            5'd17: v = 34'sh00001FFF;
            5'd18: v = 34'sh00000FFF;
            5'd19: v = 34'sh000007FF;
            5'd20: v = 34'sh000003FF;
            5'd21: v = 34'sh000001FF;
            5'd22: v = 34'sh000000FF;
            5'd23: v = 34'sh0000007F;
            5'd24: v = 34'sh0000003F;
            5'd25: v = 34'sh0000001F;
            5'd26: v = 34'sh0000000F;
            5'd27: v = 34'sh00000008;
            5'd28: v = 34'sh00000004;
            5'd29: v = 34'sh00000002;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[sv/euler_to_quaternion.sv]
// Top level of the Euler roll, pitch and yaw to unit quaternion converter.
// A word is taken in every cycle (busy stays low) and its quaternion appears
// on o_result with o_done after one input register, 30 CORDIC cells and six
// product, rounding and output stages, 37 register stages in all. The receiver
// cannot stall.
module euler_to_quaternion (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  e2q_pkg::t_in_word     i_angles,
    output logic                  o_done,
    output e2q_pkg::t_out_word    o_result
);

    localparam int N = e2q_pkg::CORDIC_STEPS;
    localparam int SHL = 29 - (e2q_pkg::ANGLE_BITS - 3);

    logic                 v [0:N];
    e2q_pkg::t_cell_bus   b [0:N];
    e2q_pkg::t_cell_bus   n_bus;
    e2q_pkg::t_cell_bus   r_bus;
    logic                 r_valid;
    logic signed [e2q_pkg::ZW-1:0] h [0:2];

    assign busy = 1'b0;
    assign h[0] = e2q_pkg::ZW'(i_angles.roll_angle) <<< SHL;
    assign h[1] = e2q_pkg::ZW'(i_angles.pitch_angle) <<< SHL;
    assign h[2] = e2q_pkg::ZW'(i_angles.yaw_angle) <<< SHL;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_bus[k].x = e2q_pkg::FIX_INV_GAIN;
            n_bus[k].y = '0;
            n_bus[k].z = h[k];
            n_bus[k].flip = 1'b0;
            if (h[k] > e2q_pkg::FIX_HALF_PI) begin
                n_bus[k].z = h[k] - e2q_pkg::FIX_PI;
                n_bus[k].flip = 1'b1;
            end else if (h[k] < -e2q_pkg::FIX_HALF_PI) begin
                n_bus[k].z = h[k] + e2q_pkg::FIX_PI;
                n_bus[k].flip = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= start;
        end
        r_bus <= n_bus;
    end

    assign v[0] = r_valid;
    assign b[0] = r_bus;

    for (genvar g = 0; g < N; g++) begin : g_cell
        e2q_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (5'(g)),
            .i_valid (v[g]),
            .i_bus   (b[g]),
            .o_valid (v[g+1]),
            .o_bus   (b[g+1])
        );
    end

    e2q_combine u_combine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v[N]),
        .i_bus   (b[N]),
        .o_valid (o_done),
        .o_word  (o_result)
    );

endmodule

[sv/e2q_cell.sv]
// One CORDIC rotation cell that turns all three angles by one step and hands them on.
module e2q_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [4:0]            i_step,
    input  logic                  i_valid,
    input  e2q_pkg::t_cell_bus    i_bus,
    output logic                  o_valid,
    output e2q_pkg::t_cell_bus    o_bus
);

    e2q_pkg::t_cell_bus n_bus;
    e2q_pkg::t_cell_bus r_bus;
    logic               r_valid;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_bus[k] = i_bus[k];
            if (i_bus[k].z >= 0) begin
                n_bus[k].x = i_bus[k].x - (i_bus[k].y >>> i_step);
                n_bus[k].y = i_bus[k].y + (i_bus[k].x >>> i_step);
                n_bus[k].z = i_bus[k].z - e2q_pkg::atan_value(i_step);
            end else begin
                n_bus[k].x = i_bus[k].x + (i_bus[k].y >>> i_step);
                n_bus[k].y = i_bus[k].y - (i_bus[k].x >>> i_step);
                n_bus[k].z = i_bus[k].z + e2q_pkg::atan_value(i_step);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_bus <= n_bus;
    end

    assign o_valid = r_valid;
    assign o_bus = r_bus;

endmodule

[sv/e2q_combine.sv]
// Pipelined triple products, rounding and saturation that build the quaternion.
module e2q_combine (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  e2q_pkg::t_cell_bus    i_bus,
    output logic                  o_valid,
    output e2q_pkg::t_out_word    o_word
);

    localparam int PW = 64;
    localparam int SH = 60 - (e2q_pkg::QUAT_BITS - 2);

    logic signed [31:0] r_sr, r_cr, r_sp, r_cp, r_sy, r_cy;
    logic signed [31:0] r2_sy, r2_cy;
    logic signed [PW-1:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [31:0] r_q0, r_q1, r_q2, r_q3, r3_sy, r3_cy;
    logic signed [PW-1:0] r_t [0:7];
    logic signed [PW-1:0] r_s [0:3];
    e2q_pkg::t_out_word   r_word;
    logic [5:0]           r_v;

    function automatic logic signed [31:0] rnd30(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] t;
        t = (v + (64'sd1 <<< 29)) >>> 30;
        return t[31:0];
    endfunction

    function automatic logic signed [e2q_pkg::QUAT_BITS-1:0] sat(
        input logic signed [PW-1:0] v);
        logic signed [PW-1:0] t;
        logic signed [PW-1:0] one;
        one = 64'sd1 <<< (e2q_pkg::QUAT_BITS - 2);
        t = (v + (64'sd1 <<< (SH - 1))) >>> SH;
        if (t > one) begin
            t = one;
        end else if (t < -one) begin
            t = -one;
        end
        return t[e2q_pkg::QUAT_BITS-1:0];
    endfunction

    function automatic logic signed [31:0] fin(input e2q_pkg::t_cordic c, input logic sn);
        logic signed [e2q_pkg::XW-1:0] v;
        v = sn ? c.y : c.x;
        if (c.flip) begin
            v = -v;
        end
        return v[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[4:0], i_valid};
        end
        r_sr <= fin(i_bus[0], 1'b1);
        r_cr <= fin(i_bus[0], 1'b0);
        r_sp <= fin(i_bus[1], 1'b1);
        r_cp <= fin(i_bus[1], 1'b0);
        r_sy <= fin(i_bus[2], 1'b1);
        r_cy <= fin(i_bus[2], 1'b0);
        r_p0 <= PW'(r_sr * r_cp);
        r_p1 <= PW'(r_cr * r_sp);
        r_p2 <= PW'(r_cr * r_cp);
        r_p3 <= PW'(r_sr * r_sp);
        r2_sy <= r_sy;
        r2_cy <= r_cy;
        r_q0 <= rnd30(r_p0);
        r_q1 <= rnd30(r_p1);
        r_q2 <= rnd30(r_p2);
        r_q3 <= rnd30(r_p3);
        r3_sy <= r2_sy;
        r3_cy <= r2_cy;
        r_t[0] <= PW'(r_q0 * r3_cy);
        r_t[1] <= PW'(r_q1 * r3_sy);
        r_t[2] <= PW'(r_q1 * r3_cy);
        r_t[3] <= PW'(r_q0 * r3_sy);
        r_t[4] <= PW'(r_q2 * r3_sy);
        r_t[5] <= PW'(r_q3 * r3_cy);
        r_t[6] <= PW'(r_q2 * r3_cy);
        r_t[7] <= PW'(r_q3 * r3_sy);
        r_s[0] <= r_t[0] - r_t[1];
        r_s[1] <= r_t[2] + r_t[3];
        r_s[2] <= r_t[4] - r_t[5];
        r_s[3] <= r_t[6] + r_t[7];
        r_word.quat_x <= sat(r_s[0]);
        r_word.quat_y <= sat(r_s[1]);
        r_word.quat_z <= sat(r_s[2]);
        r_word.quat_w <= sat(r_s[3]);
    end

    assign o_valid = r_v[5];
    assign o_word = r_word;

endmodule

[tb/tb.sv]
// Testbench for the Euler angle to quaternion converter, checked against its own predictor.
`timescale 1ns / 100ps

module tb;

    localparam int LATENCY = 38;
    localparam longint CYCLE_LIMIT = 200000;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    e2q_pkg::t_in_word i_angles;
    logic o_done;
    e2q_pkg::t_out_word o_result;

    e2q_pkg::t_out_word quat_queue[$];
    int errors;
    longint cycles;

    euler_to_quaternion uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_angles(i_angles),
        .o_done(o_done),
        .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint fshift(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint rshift(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint atan_entry(input int i);
        longint tab[30] = '{
            64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
            64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
            64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
            64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
            64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
            64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002};
        return tab[i];
    endfunction

    function automatic void half_angle_sincos(
        input logic signed [e2q_pkg::ANGLE_BITS-1:0] ang,
        output longint s, output longint c);
        longint h, x, y, z, dx, dy;
        bit flip;
        h = longint'(ang) * (longint'(1) << (29 - (e2q_pkg::ANGLE_BITS - 3)));
        flip = 1'b0;
        if (h > 64'sd1686629713) begin
            h -= 64'sd3373259426;
            flip = 1'b1;
        end else if (h < -64'sd1686629713) begin
            h += 64'sd3373259426;
            flip = 1'b1;
        end
        x = 64'sd652032874;
        y = 0;
        z = h;
        for (int i = 0; i < 30; i++) begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= atan_entry(i);
            end else begin
                x += dx;
                y -= dy;
                z += atan_entry(i);
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        s = y;
        c = x;
    endfunction

    function automatic longint prod3(input longint a, input longint b, input longint c);
        return rshift(a * b, 30) * c;
    endfunction

    function automatic logic signed [e2q_pkg::QUAT_BITS-1:0] to_q14(input longint q60);
        longint one, v;
        one = longint'(1) << (e2q_pkg::QUAT_BITS - 2);
        v = rshift(q60, 60 - (e2q_pkg::QUAT_BITS - 2));
        if (v > one) v = one;
        if (v < -one) v = -one;
        return v[e2q_pkg::QUAT_BITS-1:0];
    endfunction

    function automatic e2q_pkg::t_out_word predict_quat(input e2q_pkg::t_in_word a);
        longint sr, cr, sp, cp, sy, cy;
        e2q_pkg::t_out_word q;
        half_angle_sincos(a.roll_angle, sr, cr);
        half_angle_sincos(a.pitch_angle, sp, cp);
        half_angle_sincos(a.yaw_angle, sy, cy);
        q.quat_x = to_q14(prod3(sr, cp, cy) - prod3(cr, sp, sy));
        q.quat_y = to_q14(prod3(cr, sp, cy) + prod3(sr, cp, sy));
        q.quat_z = to_q14(prod3(cr, cp, sy) - prod3(sr, sp, cy));
        q.quat_w = to_q14(prod3(cr, cp, cy) + prod3(sr, sp, sy));
        return q;
    endfunction

    task automatic send_angles(input e2q_pkg::t_in_word a, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_angles <= a;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        quat_queue.push_back(predict_quat(a));
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("euler_to_quaternion: mismatch");
            $finish;
        end
        if (i_rst_n && o_done) begin
            if (quat_queue.size() == 0) begin
                $display("%0t unexpected word: actual %h", $time, o_result);
                errors++;
            end else begin
                e2q_pkg::t_out_word e;
                e = quat_queue.pop_front();
                if (e.quat_x !== o_result.quat_x || e.quat_y !== o_result.quat_y ||
                    e.quat_z !== o_result.quat_z || e.quat_w !== o_result.quat_w) begin
                    $display("%0t expected %h actual %h", $time, e, o_result);
                    errors++;
                end
            end
        end
    end

    function automatic logic signed [15:0] edge_angle(input int k);
        case (k % 8)
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'sh3244;
            4: return -16'sh3244;
            5: return 16'sh3243;
            6: return 16'sh6488;
            default: return 16'shFFFF;
        endcase
    endfunction

    task automatic test_extremes();
        e2q_pkg::t_in_word a;
        for (int k = 0; k < 24; k++) begin
            a.roll_angle = edge_angle(k);
            a.pitch_angle = edge_angle(k / 3 + 1);
            a.yaw_angle = edge_angle(k * 5 + 2);
            send_angles(a, 0);
        end
    endtask

    task automatic test_random_back_to_back();
        e2q_pkg::t_in_word a;
        for (int k = 0; k < 300; k++) begin
            a = e2q_pkg::t_in_word'({16'($urandom), 16'($urandom), 16'($urandom)});
            send_angles(a, 0);
        end
    endtask

    task automatic test_random_gaps();
        e2q_pkg::t_in_word a;
        for (int k = 0; k < 650; k++) begin
            a = e2q_pkg::t_in_word'({16'($urandom), 16'($urandom), 16'($urandom)});
            if (k % 5 == 0) a.pitch_angle = $urandom_range(0, 1) ? 16'sh3244 : -16'sh3244;
            send_angles(a, (k / 100) % 2 ? 0 : $urandom_range(0, 4));
        end
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_angles = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_random_back_to_back();
        test_random_gaps();
        start <= 1'b0;
        while (quat_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0 && quat_queue.size() == 0) begin
            $display("euler_to_quaternion: match");
        end else begin
            $display("euler_to_quaternion: mismatch");
        end
        $finish;
    end

endmodule

[files.f]
sv/e2q_pkg.sv
sv/e2q_cell.sv
sv/e2q_combine.sv
sv/euler_to_quaternion.sv
tb/tb.sv
